/* hw/rtl/triangle_tangent_generator_defines.svh */
// Assertion macros shared by the tangent generator.
`ifndef TRIANGLE_TANGENT_GENERATOR_DEFINES_SVH
`define TRIANGLE_TANGENT_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TTG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ttg check failed");

// Next-cycle implication, checked out of reset.
`define TTG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ttg check failed");

`endif

/* hw/rtl/ttg_pkg.sv */
package ttg_pkg;

  localparam int INDEX_BITS = 24;
  localparam int POS_BITS   = 24;
  localparam int TEX_BITS   = 16;
  localparam int FIELD_IDX  = 24;
  localparam int EDGE_BITS  = 25;
  localparam int DELTA_BITS = 17;
  localparam int PROD_BITS  = 42;
  localparam int ACC_BITS   = 43;
  localparam int NORM_BITS  = 30;
  localparam int SQ_BITS    = 60;
  localparam int SUM_BITS   = 62;
  localparam int ROOT_BITS  = 63;
  localparam int LEN_BITS   = 32;
  localparam int NUM_BITS   = 46;
  localparam int QUO_BITS   = 15;
  localparam int REM_BITS   = 33;
  localparam int OUT_BITS   = 16;

  typedef struct packed {
    logic signed [POS_BITS-1:0]  pos_x;
    logic signed [POS_BITS-1:0]  pos_y;
    logic signed [POS_BITS-1:0]  pos_z;
    logic signed [TEX_BITS-1:0]  tex_u;
    logic signed [TEX_BITS-1:0]  tex_v;
    logic        [FIELD_IDX-1:0] corner_index;
    logic                        last_corner;
  } corner_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0]  tangent_x;
    logic signed [OUT_BITS-1:0]  tangent_y;
    logic signed [OUT_BITS-1:0]  tangent_z;
    logic        [FIELD_IDX-1:0] first_index;
    logic        [FIELD_IDX-1:0] second_index;
    logic        [FIELD_IDX-1:0] third_index;
    logic                        degenerate;
  } result_t;

  typedef struct packed {
    logic signed [EDGE_BITS-1:0]  e1x;
    logic signed [EDGE_BITS-1:0]  e1y;
    logic signed [EDGE_BITS-1:0]  e1z;
    logic signed [EDGE_BITS-1:0]  e2x;
    logic signed [EDGE_BITS-1:0]  e2y;
    logic signed [EDGE_BITS-1:0]  e2z;
    logic signed [DELTA_BITS-1:0] du1;
    logic signed [DELTA_BITS-1:0] dv1;
    logic signed [DELTA_BITS-1:0] du2;
    logic signed [DELTA_BITS-1:0] dv2;
    logic        [INDEX_BITS-1:0] idx0;
    logic        [INDEX_BITS-1:0] idx1;
    logic        [INDEX_BITS-1:0] idx2;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* hw/rtl/ttg_front.sv */
module ttg_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   corner_valid,
  output logic                   corner_stall,
  input  ttg_pkg::corner_t       corner,
  output logic                   push,
  output ttg_pkg::job_t          job,
  input  ttg_pkg::queue_status_t q_stat
);

  logic [1:0]       count;
  ttg_pkg::corner_t held0;
  ttg_pkg::corner_t held1;
  logic             accept;

  assign corner_stall = q_stat.full;
  assign accept       = corner_valid && !q_stat.full;
  assign push         = accept && (count == 2'd2);

  always_comb begin
    job.e1x  = ttg_pkg::EDGE_BITS'(held1.pos_x) - ttg_pkg::EDGE_BITS'(held0.pos_x);
    job.e1y  = ttg_pkg::EDGE_BITS'(held1.pos_y) - ttg_pkg::EDGE_BITS'(held0.pos_y);
    job.e1z  = ttg_pkg::EDGE_BITS'(held1.pos_z) - ttg_pkg::EDGE_BITS'(held0.pos_z);
    job.e2x  = ttg_pkg::EDGE_BITS'(corner.pos_x) - ttg_pkg::EDGE_BITS'(held0.pos_x);
    job.e2y  = ttg_pkg::EDGE_BITS'(corner.pos_y) - ttg_pkg::EDGE_BITS'(held0.pos_y);
    job.e2z  = ttg_pkg::EDGE_BITS'(corner.pos_z) - ttg_pkg::EDGE_BITS'(held0.pos_z);
    job.du1  = ttg_pkg::DELTA_BITS'(held1.tex_u) - ttg_pkg::DELTA_BITS'(held0.tex_u);
    job.dv1  = ttg_pkg::DELTA_BITS'(held1.tex_v) - ttg_pkg::DELTA_BITS'(held0.tex_v);
    job.du2  = ttg_pkg::DELTA_BITS'(corner.tex_u) - ttg_pkg::DELTA_BITS'(held0.tex_u);
    job.dv2  = ttg_pkg::DELTA_BITS'(corner.tex_v) - ttg_pkg::DELTA_BITS'(held0.tex_v);
    job.idx0 = ttg_pkg::INDEX_BITS'(held0.corner_index);
    job.idx1 = ttg_pkg::INDEX_BITS'(held1.corner_index);
    job.idx2 = ttg_pkg::INDEX_BITS'(corner.corner_index);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (accept) begin
      if (count == 2'd2 || corner.last_corner) begin
        count <= 2'd0;
      end else begin
        count <= count + 2'd1;
      end
    end
  end

  // hold the first two corners of the triangle
  always_ff @(posedge clk) begin
    if (accept && count == 2'd0) begin
      held0 <= corner;
    end
    if (accept && count == 2'd1) begin
      held1 <= corner;
    end
  end

endmodule

/* hw/rtl/ttg_queue.sv */
module ttg_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ttg_pkg::job_t          din,
  output ttg_pkg::queue_status_t stat,
  input  logic                   pop,
  output ttg_pkg::job_t          dout
);

  ttg_pkg::job_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          do_push;
  logic          do_pop;

  assign stat.full  = (fill == 2'd2);
  assign stat.empty = (fill == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= din;
    end
  end

endmodule

/* hw/rtl/ttg_back.sv */
module ttg_back (
  input  logic                   clk,
  input  logic                   rst,
  input  ttg_pkg::queue_status_t q_stat,
  input  ttg_pkg::job_t          job_in,
  output logic                   pop,
  output logic                   result_valid,
  input  logic                   result_stall,
  output ttg_pkg::result_t       result
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_MAG, S_MAX, S_NORM, S_SQ, S_SQRT, S_DIV_INIT, S_DIV_STEP, S_DONE
  } state_t;

  state_t                               state;
  ttg_pkg::job_t                        job;
  logic [3:0]                           cnt;
  logic [1:0]                           comp;
  logic signed [ttg_pkg::ACC_BITS-1:0]  acc [4];
  logic [ttg_pkg::ACC_BITS-1:0]         mag [3];
  logic [2:0]                           neg;
  logic [ttg_pkg::ACC_BITS-1:0]         amax;
  logic                                 degen;
  logic [ttg_pkg::SUM_BITS-1:0]         sum;
  logic [ttg_pkg::ROOT_BITS-1:0]        sx;
  logic [ttg_pkg::ROOT_BITS-1:0]        sr;
  logic [ttg_pkg::ROOT_BITS-1:0]        sbit;
  logic [ttg_pkg::LEN_BITS-1:0]         len;
  logic [ttg_pkg::REM_BITS-1:0]         rem;
  logic [ttg_pkg::QUO_BITS-1:0]         numlo;
  logic [ttg_pkg::QUO_BITS-1:0]         quo;
  logic [ttg_pkg::OUT_BITS-1:0]         tan [3];

  logic signed [ttg_pkg::EDGE_BITS-1:0]  mul_a;
  logic signed [ttg_pkg::DELTA_BITS-1:0] mul_b;
  logic signed [ttg_pkg::PROD_BITS-1:0]  prod;
  logic [ttg_pkg::ACC_BITS-1:0]          mag_c [3];
  logic                                  degen_c;
  logic [ttg_pkg::ACC_BITS-1:0]          max01;
  logic [ttg_pkg::NORM_BITS-1:0]         cn;
  logic [ttg_pkg::SQ_BITS-1:0]           sq;
  logic [ttg_pkg::ROOT_BITS-1:0]         trial;
  logic [ttg_pkg::NUM_BITS-1:0]          numer;
  logic [ttg_pkg::REM_BITS-1:0]          dd;
  logic [ttg_pkg::REM_BITS:0]            tr;
  logic                                  ge;
  logic [ttg_pkg::QUO_BITS-1:0]          quo_next;
  logic [ttg_pkg::OUT_BITS-1:0]          qext;
  logic                                  out_free;

  assign pop = (state == S_IDLE) && !q_stat.empty;

  // one shared multiplier: tangent mix first, then the determinant
  always_comb begin
    case (cnt[2:0])
      3'd0: begin mul_a = job.e1x; mul_b = job.dv2; end
      3'd1: begin mul_a = job.e2x; mul_b = job.dv1; end
      3'd2: begin mul_a = job.e1y; mul_b = job.dv2; end
      3'd3: begin mul_a = job.e2y; mul_b = job.dv1; end
      3'd4: begin mul_a = job.e1z; mul_b = job.dv2; end
      3'd5: begin mul_a = job.e2z; mul_b = job.dv1; end
      3'd6: begin mul_a = ttg_pkg::EDGE_BITS'(job.du1); mul_b = job.dv2; end
      default: begin mul_a = ttg_pkg::EDGE_BITS'(job.du2); mul_b = job.dv1; end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = acc[i][ttg_pkg::ACC_BITS-1] ? (~acc[i] + 1'b1) : acc[i];
    end
    degen_c = (acc[3] == '0) || (acc[0] == '0 && acc[1] == '0 && acc[2] == '0);
  end

  assign max01    = (mag[0] > mag[1]) ? mag[0] : mag[1];
  assign cn       = mag[comp][ttg_pkg::NORM_BITS-1:0];
  assign sq       = cn * cn;
  assign trial    = sr + sbit;
  assign numer    = {cn, {ttg_pkg::QUO_BITS{1'b0}}} + ttg_pkg::NUM_BITS'(len);
  assign dd       = {len, 1'b0};
  assign tr       = {rem, numlo[ttg_pkg::QUO_BITS-1]};
  assign ge       = (tr >= (ttg_pkg::REM_BITS+1)'(dd));
  assign quo_next = {quo[ttg_pkg::QUO_BITS-2:0], ge};
  assign qext     = {1'b0, quo_next};
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      // drop the valid after a transfer unless the next result loads now
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            job   <= job_in;
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (!cnt[0]) begin
            acc[cnt[2:1]] <= ttg_pkg::ACC_BITS'(prod);
          end else begin
            acc[cnt[2:1]] <= acc[cnt[2:1]] - ttg_pkg::ACC_BITS'(prod);
          end
          cnt <= cnt + 4'd1;
          if (cnt[2:0] == 3'd7) begin
            state <= S_MAG;
          end
        end
        S_MAG: begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag_c[i];
            neg[i] <= acc[i][ttg_pkg::ACC_BITS-1];
            tan[i] <= '0;
          end
          degen <= degen_c;
          state <= degen_c ? S_DONE : S_MAX;
        end
        S_MAX: begin
          amax  <= (mag[2] > max01) ? mag[2] : max01;
          state <= S_NORM;
        end
        S_NORM: begin
          // move the largest magnitude's top bit onto bit 29
          if (amax[ttg_pkg::ACC_BITS-1:ttg_pkg::NORM_BITS] != '0) begin
            amax <= amax >> 1;
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else if (!amax[ttg_pkg::NORM_BITS-1]) begin
            amax <= amax << 1;
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] << 1;
            end
          end else begin
            comp  <= 2'd0;
            sum   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (comp == 2'd2) begin
            sx    <= ttg_pkg::ROOT_BITS'(sum + ttg_pkg::SUM_BITS'(sq));
            sr    <= '0;
            sbit  <= ttg_pkg::ROOT_BITS'(1) << (ttg_pkg::ROOT_BITS - 1);
            state <= S_SQRT;
          end else begin
            sum  <= sum + ttg_pkg::SUM_BITS'(sq);
            comp <= comp + 2'd1;
          end
        end
        S_SQRT: begin
          if (sbit == '0) begin
            len   <= sr[ttg_pkg::LEN_BITS-1:0];
            comp  <= 2'd0;
            state <= S_DIV_INIT;
          end else begin
            if (sx >= trial) begin
              sx <= sx - trial;
              sr <= (sr >> 1) + sbit;
            end else begin
              sr <= sr >> 1;
            end
            sbit <= sbit >> 2;
          end
        end
        S_DIV_INIT: begin
          rem   <= ttg_pkg::REM_BITS'(numer[ttg_pkg::NUM_BITS-1:ttg_pkg::QUO_BITS]);
          numlo <= numer[ttg_pkg::QUO_BITS-1:0];
          quo   <= '0;
          cnt   <= 4'(ttg_pkg::QUO_BITS - 1);
          state <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          rem   <= ge ? ttg_pkg::REM_BITS'(tr - (ttg_pkg::REM_BITS+1)'(dd))
                      : ttg_pkg::REM_BITS'(tr);
          numlo <= numlo << 1;
          quo   <= quo_next;
          cnt   <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            // the overall sign always comes out opposite to the mix
            tan[comp] <= neg[comp] ? qext : (~qext + 1'b1);
            if (comp == 2'd2) begin
              state <= S_DONE;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_DIV_INIT;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            result_valid        <= 1'b1;
            result.tangent_x    <= tan[0];
            result.tangent_y    <= tan[1];
            result.tangent_z    <= tan[2];
            result.first_index  <= ttg_pkg::FIELD_IDX'(job.idx0);
            result.second_index <= ttg_pkg::FIELD_IDX'(job.idx1);
            result.third_index  <= ttg_pkg::FIELD_IDX'(job.idx2);
            result.degenerate   <= degen;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/triangle_tangent_generator.sv */
// channel   direction  payload              transfer when
// corner    in         ttg_pkg::corner_t    corner_valid && !corner_stall
// result    out        ttg_pkg::result_t    result_valid && !result_stall
//
// Corners 0 and 1 of a triangle are held in the front end; the third is queued (two deep).
// In the back end a triangle takes 8 multiply steps, up to 29 single-bit normalising shifts,
// 3 squares, 33 root steps and 3 x 16 divide steps; a degenerate one goes from the magnitudes to the output.
// The shared multiplier, the bit-serial root and the radix-2 divider do that work.
// Reset (rst, synchronous) clears the corner count, the queue, the back-end state and the result valid.
// A stalled result holds; the back end waits for it while the front end takes corners until the queue is full.
`include "triangle_tangent_generator_defines.svh"

module triangle_tangent_generator (
  input  logic             clk,
  input  logic             rst,
  input  logic             corner_valid,
  output logic             corner_stall,
  input  ttg_pkg::corner_t corner,
  output logic             result_valid,
  input  logic             result_stall,
  output ttg_pkg::result_t result
);

  logic                   push;
  logic                   pop;
  ttg_pkg::job_t          job_w;
  ttg_pkg::job_t          job_r;
  ttg_pkg::queue_status_t q_stat;
  logic                   tan_zero;

  ttg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .corner_valid (corner_valid),
    .corner_stall (corner_stall),
    .corner       (corner),
    .push         (push),
    .job          (job_w),
    .q_stat       (q_stat)
  );

  ttg_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (job_w),
    .stat (q_stat),
    .pop  (pop),
    .dout (job_r)
  );

  ttg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .job_in       (job_r),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign tan_zero = (result.tangent_x == '0) && (result.tangent_y == '0) &&
                    (result.tangent_z == '0);

  `TTG_ASSERT_IMP(a_degen_zero, result_valid && result.degenerate, tan_zero)
  `TTG_ASSERT_IMP(a_unit_nonzero, result_valid && !result.degenerate, !tan_zero)
  `TTG_ASSERT_IMP(a_push_room, push, !q_stat.full)
  `TTG_ASSERT_NXT(a_pop_once, pop, !pop)

endmodule

/* tb/tb_triangle_tangent_generator.sv */
`timescale 1ns / 1ps

module tb_triangle_tangent_generator;

  localparam int CYCLE_LIMIT = 600000;

  logic             clk;
  logic             rst;
  logic             corner_valid;
  logic             corner_stall;
  ttg_pkg::corner_t corner;
  logic             result_valid;
  logic             result_stall;
  ttg_pkg::result_t result;

  triangle_tangent_generator uut (
    .clk          (clk),
    .rst          (rst),
    .corner_valid (corner_valid),
    .corner_stall (corner_stall),
    .corner       (corner),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  ttg_pkg::corner_t pending_corners[$];
  ttg_pkg::result_t expected_tangents[$];

  // predictor state
  int unsigned      pred_count;
  logic signed [63:0] held_pos[6];
  logic signed [63:0] held_uv[4];
  logic [ttg_pkg::INDEX_BITS-1:0] held_idx[2];

  int  errors;
  int  triangles_seen;
  int  degenerate_seen;
  int  cycle_count;
  bit  feed_done;
  bit  calm_phase;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void predict_corner(ttg_pkg::corner_t c);
    logic signed [63:0] px[3];
    logic signed [63:0] du1, dv1, du2, dv2, det, hand;
    logic signed [63:0] m[3];
    logic [63:0] mag[3];
    logic [63:0] top, sumsq, len, q;
    int unsigned p;
    bit flip, neg;
    ttg_pkg::result_t r;
    px[0] = c.pos_x;
    px[1] = c.pos_y;
    px[2] = c.pos_z;
    if (pred_count < 2) begin
      for (int i = 0; i < 3; i++) held_pos[pred_count*3+i] = px[i];
      held_uv[pred_count*2]   = c.tex_u;
      held_uv[pred_count*2+1] = c.tex_v;
      held_idx[pred_count]    = ttg_pkg::INDEX_BITS'(c.corner_index);
      pred_count++;
    end else begin
      du1 = held_uv[2] - held_uv[0];
      dv1 = held_uv[3] - held_uv[1];
      du2 = 64'(c.tex_u) - held_uv[0];
      dv2 = 64'(c.tex_v) - held_uv[1];
      det = du1 * dv2 - du2 * dv1;
      hand = dv1 * du2 - dv2 * du1;
      for (int i = 0; i < 3; i++)
        m[i] = dv2 * (held_pos[3+i] - held_pos[i]) - dv1 * (px[i] - held_pos[i]);
      r = '0;
      r.first_index  = ttg_pkg::FIELD_IDX'(held_idx[0]);
      r.second_index = ttg_pkg::FIELD_IDX'(held_idx[1]);
      r.third_index  = ttg_pkg::FIELD_IDX'(ttg_pkg::INDEX_BITS'(c.corner_index));
      r.degenerate = (det == 0) || (m[0] == 0 && m[1] == 0 && m[2] == 0);
      if (!r.degenerate) begin
        flip = (det < 0) != (hand < 0);
        top = '0;
        for (int i = 0; i < 3; i++) begin
          mag[i] = (m[i] < 0) ? -m[i] : m[i];
          if (mag[i] > top) top = mag[i];
        end
        p = 0;
        while ((top >> (p + 1)) != 0) p++;
        sumsq = '0;
        for (int i = 0; i < 3; i++) begin
          mag[i] = (p > 29) ? mag[i] >> (p - 29) : mag[i] << (29 - p);
          sumsq += mag[i] * mag[i];
        end
        len = int_sqrt(sumsq);
        for (int i = 0; i < 3; i++) begin
          q = (64'd32768 * mag[i] + len) / (2 * len);
          neg = (m[i] < 0) != flip;
          if (neg) q = -q;
          if (i == 0) r.tangent_x = q[15:0];
          else if (i == 1) r.tangent_y = q[15:0];
          else r.tangent_z = q[15:0];
        end
      end
      expected_tangents.push_back(r);
      pred_count = 0;
    end
    if (c.last_corner) pred_count = 0;
  endfunction

  function automatic ttg_pkg::corner_t random_corner(bit narrow);
    ttg_pkg::corner_t c;
    if (narrow) begin
      c.pos_x = 24'($signed($urandom_range(0, 4000)) - 2000);
      c.pos_y = 24'($signed($urandom_range(0, 4000)) - 2000);
      c.pos_z = 24'($signed($urandom_range(0, 4000)) - 2000);
      c.tex_u = 16'($signed($urandom_range(0, 200)) - 100);
      c.tex_v = 16'($signed($urandom_range(0, 200)) - 100);
    end else begin
      c.pos_x = 24'($urandom);
      c.pos_y = 24'($urandom);
      c.pos_z = 24'($urandom);
      c.tex_u = 16'($urandom);
      c.tex_v = 16'($urandom);
    end
    c.corner_index = 24'($urandom);
    c.last_corner  = 1'b0;
    return c;
  endfunction

  task automatic push_corner(ttg_pkg::corner_t c);
    pending_corners.push_back(c);
  endtask

  initial begin
    ttg_pkg::corner_t c;
    int kind;
    rst = 1'b1;
    corner_valid = 1'b0;
    corner = '0;
    result_stall = 1'b0;
    errors = 0;
    triangles_seen = 0;
    degenerate_seen = 0;
    cycle_count = 0;
    feed_done = 1'b0;
    calm_phase = 1'b0;
    pred_count = 0;

    // extremes, a regular triangle
    c = '0; c.pos_x = 24'sh7FFFFF; c.pos_y = 24'sh800000; c.pos_z = 24'sh7FFFFF;
    c.tex_u = 16'sh8000; c.tex_v = 16'sh8000; c.corner_index = 24'hFFFFFF;
    push_corner(c);
    c.pos_x = 24'sh800000; c.pos_y = 24'sh7FFFFF; c.pos_z = 24'sh800000;
    c.tex_u = 16'sh7FFF; c.tex_v = 16'sh8000; c.corner_index = 24'h000000;
    push_corner(c);
    c.pos_x = 24'sh000000; c.pos_y = 24'sh800000; c.pos_z = 24'sh7FFFFF;
    c.tex_u = 16'sh8000; c.tex_v = 16'sh7FFF; c.corner_index = 24'hA5A5A5;
    push_corner(c);
    // zero determinant: identical texture coordinates
    for (int i = 0; i < 3; i++) begin
      c = random_corner(0); c.tex_u = 16'sh1234; c.tex_v = 16'sh0F0F;
      push_corner(c);
    end
    // zero tangent: coincident positions
    for (int i = 0; i < 3; i++) begin
      c = random_corner(0); c.pos_x = 24'sh000010; c.pos_y = -24'sh20; c.pos_z = '0;
      push_corner(c);
    end
    // mirrored mapping flips handedness
    for (int i = 0; i < 3; i++) begin
      c = random_corner(1); c.tex_u = (i == 1) ? 16'sh4000 : 16'sh0;
      c.tex_v = (i == 2) ? -16'sh4000 : 16'sh0;
      push_corner(c);
    end
    // mesh end on the first and second corners drops the partial triangle
    c = random_corner(0); c.last_corner = 1'b1; push_corner(c);
    c = random_corner(0); push_corner(c);
    c = random_corner(0); c.last_corner = 1'b1; push_corner(c);
    // mesh end on a third corner still completes it
    for (int i = 0; i < 3; i++) begin
      c = random_corner(0); c.last_corner = (i == 2); push_corner(c);
    end

    for (int n = 0; n < 1300; ) begin
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        for (int i = 0; i < 3; i++) begin
          c = random_corner(kind < 40);
          if (kind < 10 && i > 0) c.tex_v = pending_corners[$].tex_v;
          c.last_corner = (i == 2) && ($urandom_range(0, 9) == 0);
          push_corner(c);
        end
        n += 3;
      end else begin
        c = random_corner(kind[0]);
        c.last_corner = 1'($urandom_range(0, 1));
        push_corner(c);
        n++;
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (corner_valid && !corner_stall) begin
        predict_corner(corner);
        void'(pending_corners.pop_front());
      end
      if ((!corner_valid || !corner_stall)) begin
        if (pending_corners.size() > 0 && (calm_phase || $urandom_range(0, 99) >= 23) &&
            !(corner_valid && !corner_stall && pending_corners.size() == 0)) begin
          corner_valid <= 1'b1;
          corner <= pending_corners[0];
        end else begin
          corner_valid <= 1'b0;
        end
      end
      if (pending_corners.size() == 0) feed_done <= 1'b1;
    end
  end

  // a calm stretch in the middle of the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    calm_phase <= (cycle_count > 10000 && cycle_count < 25000);
    if (!rst) result_stall <= !calm_phase && ($urandom_range(0, 99) < 23);
  end

  // monitor
  always @(posedge clk) begin
    ttg_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      triangles_seen++;
      if (expected_tangents.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        want = expected_tangents.pop_front();
        if (result.degenerate) degenerate_seen++;
        if (result.tangent_x !== want.tangent_x) begin
          $error("tangent_x expected %0d got %0d", want.tangent_x, result.tangent_x);
          errors++;
        end
        if (result.tangent_y !== want.tangent_y) begin
          $error("tangent_y expected %0d got %0d", want.tangent_y, result.tangent_y);
          errors++;
        end
        if (result.tangent_z !== want.tangent_z) begin
          $error("tangent_z expected %0d got %0d", want.tangent_z, result.tangent_z);
          errors++;
        end
        if (result.first_index !== want.first_index) begin
          $error("first_index expected %0h got %0h", want.first_index, result.first_index);
          errors++;
        end
        if (result.second_index !== want.second_index) begin
          $error("second_index expected %0h got %0h", want.second_index,
                 result.second_index);
          errors++;
        end
        if (result.third_index !== want.third_index) begin
          $error("third_index expected %0h got %0h", want.third_index, result.third_index);
          errors++;
        end
        if (result.degenerate !== want.degenerate) begin
          $error("degenerate expected %0b got %0b", want.degenerate, result.degenerate);
          errors++;
        end
      end
    end
  end

  initial begin
    @(negedge rst);
    while (!(feed_done && !corner_valid && expected_tangents.size() == 0) &&
           cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Checked %0d triangles before the cycle limit ran out.", triangles_seen);
      $display("Regression FAIL");
      $finish;
    end else begin
      // catch any stray result after the last triangle
      repeat (300) @(posedge clk);
      $display("Checked %0d triangles (%0d degenerate) under random idling on both sides.",
               triangles_seen, degenerate_seen);
      if (errors == 0 && expected_tangents.size() == 0)
        $display("Regression PASS");
      else
        $display("Regression FAIL");
      $finish;
    end
  end

endmodule
